// File: design/fwm_pkg.sv
`default_nettype none

package fwm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH = 32;
  localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic merge;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] popped;
    logic                        pop_empty;
    logic signed [OUT_WIDTH-1:0] max;
    logic                        queue_empty;
    logic                        dropped;
  } result_t;

  localparam logic signed [OUT_WIDTH-1:0] NONE_VALUE = -32'sd1;

  function automatic logic signed [OUT_WIDTH-1:0] to_out(input value_t v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[OUT_WIDTH-1:0];
  endfunction

  function automatic value_t from_in(input logic signed [OUT_WIDTH-1:0] x);
    logic signed [63:0] wide;
    wide = 64'(x);
    return wide[VALUE_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/fwm_cell.sv
`default_nettype none

module fwm_cell
  import fwm_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire value_t     push_val,
  input  wire value_t     nbr_val,
  input  wire value_t     nbr_max,
  output value_t          val,
  output value_t          suffix_max
);

  // Each cell holds one entry and the greatest value of itself and all newer entries.
  always_ff @(posedge clk) begin
    priority if (ctrl.shift) begin
      val        <= nbr_val;
      suffix_max <= nbr_max;
    end else if (ctrl.load) begin
      val        <= push_val;
      suffix_max <= push_val;
    end else if (ctrl.merge && (push_val > suffix_max)) begin
      suffix_max <= push_val;
    end
  end

endmodule

`default_nettype wire

// File: design/fifo_with_running_max_unit.sv
// Channel   Signals                                             Direction
// in        in_valid, in_stall, req_type, push_value            item in
// out       out_valid, out_stall, popped_value, pop_empty,
//           peak_value, queue_empty, push_dropped               result out
//
// Every item is finished in the cycle it is accepted, one per clock while not
// stalled; its result is registered. The row of cells shifts on a pop and
// updates every suffix maximum in parallel on a push, so no rescan is needed.
// A two-entry output buffer lets one further item in while a result is stalled.
// Reset empties the queue at once; entry contents are not cleared.
`default_nettype none

module fifo_with_running_max_unit
  import fwm_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  req_type,
  input  wire logic signed [OUT_WIDTH-1:0] push_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [OUT_WIDTH-1:0]      popped_value,
  output logic                             pop_empty,
  output logic signed [OUT_WIDTH-1:0]      peak_value,
  output logic                             queue_empty,
  output logic                             push_dropped
);

  count_t     count;
  count_t     count_next;
  value_t     cell_val [QUEUE_DEPTH];
  value_t     cell_max [QUEUE_DEPTH];
  cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
  value_t     push_val;
  result_t    res_next;
  result_t    out_res;
  result_t    skid_res;
  logic       skid_valid;
  logic       accept;
  logic       do_push;
  logic       do_pop;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign push_val = from_in(push_value);

  always_comb begin
    do_push    = 1'b0;
    do_pop     = 1'b0;
    count_next = count;
    res_next   = '{popped: NONE_VALUE, pop_empty: 1'b0, max: NONE_VALUE,
                   queue_empty: 1'b0, dropped: 1'b0};
    unique case (req_t'(req_type))
      REQ_PUSH: begin
        if (count == count_t'(QUEUE_DEPTH)) begin
          res_next.dropped = 1'b1;
        end else begin
          do_push = accept;
          count_next = count + count_t'(1);
        end
      end
      REQ_POP: begin
        if (count == '0) begin
          res_next.pop_empty = 1'b1;
        end else begin
          do_pop = accept;
          res_next.popped = to_out(cell_val[0]);
          count_next = count - count_t'(1);
        end
      end
      REQ_QUERY, REQ_SPARE: begin
      end
      default: begin
      end
    endcase

    if (count_next == '0) begin
      res_next.queue_empty = 1'b1;
    end else if (req_t'(req_type) == REQ_PUSH && count != count_t'(QUEUE_DEPTH)) begin
      if (count == '0 || push_val > cell_max[0]) begin
        res_next.max = to_out(push_val);
      end else begin
        res_next.max = to_out(cell_max[0]);
      end
    end else if (req_t'(req_type) == REQ_POP) begin
      res_next.max = to_out(cell_max[1]);
    end else begin
      res_next.max = to_out(cell_max[0]);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    value_t nbr_val;
    value_t nbr_max;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_val = '0;
      assign nbr_max = '0;
    end else begin : g_mid
      assign nbr_val = cell_val[i+1];
      assign nbr_max = cell_max[i+1];
    end

    assign cell_ctrl[i] = '{shift: do_pop,
                            load:  do_push && (count == count_t'(i)),
                            merge: do_push && (count > count_t'(i))};

    fwm_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .push_val   (push_val),
      .nbr_val    (nbr_val),
      .nbr_max    (nbr_max),
      .val        (cell_val[i]),
      .suffix_max (cell_max[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (out_valid && !out_stall) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_res <= res_next;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (accept) begin
          out_res   <= res_next;
          out_valid <= 1'b1;
        end
      end else begin
        if (accept) begin
          skid_res   <= res_next;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign popped_value = out_res.popped;
  assign pop_empty    = out_res.pop_empty;
  assign peak_value   = out_res.max;
  assign queue_empty  = out_res.queue_empty;
  assign push_dropped = out_res.dropped;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("buffered result without a result on the port");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> (peak_value == NONE_VALUE))
    else $error("empty queue reports a maximum");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && push_dropped) |-> (!queue_empty && !pop_empty))
    else $error("dropped push on a queue that was not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count changed without an accepted word");
`endif

endmodule

`default_nettype wire

// File: tb/sv/fwm_max_checker.sv
`default_nettype none

module fwm_max_checker
  import fwm_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [1:0]                  req_type,
  input  wire logic signed [OUT_WIDTH-1:0] push_value,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic signed [OUT_WIDTH-1:0] popped_value,
  input  wire logic                        pop_empty,
  input  wire logic signed [OUT_WIDTH-1:0] peak_value,
  input  wire logic                        queue_empty,
  input  wire logic                        push_dropped,
  output int                               fail_count,
  output int                               pending,
  output int                               checked
);

  timeunit 1ns;
  timeprecision 1ps;

  value_t      slot_val [QUEUE_DEPTH];
  int unsigned head_slot;
  int unsigned held;
  int unsigned max_slot;
  result_t     expected_results [$];
  result_t     due;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    head_slot = 0;
    held = 0;
    max_slot = 0;
  end

  function automatic result_t apply_word(input logic [1:0] req,
                                         input logic signed [OUT_WIDTH-1:0] pv);
    result_t     r;
    value_t      v;
    int unsigned s;
    int unsigned front;
    int unsigned i;
    r.popped = NONE_VALUE;
    r.pop_empty = 1'b0;
    r.dropped = 1'b0;
    if (req == REQ_PUSH) begin
      v = value_t'(pv);
      if (held >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        s = (head_slot + held) % QUEUE_DEPTH;
        slot_val[s] = v;
        if (held == 0 || v > slot_val[max_slot]) max_slot = s;
        held++;
      end
    end else if (req == REQ_POP) begin
      if (held == 0) begin
        r.pop_empty = 1'b1;
      end else begin
        front = head_slot;
        r.popped = slot_val[front];
        head_slot = (front + 1) % QUEUE_DEPTH;
        held--;
        if (held == 0) begin
          max_slot = head_slot;
        end else if (max_slot == front) begin
          // The maximum left the queue, so search what remains, oldest first.
          max_slot = head_slot;
          for (i = 1; i < held; i++) begin
            s = (head_slot + i) % QUEUE_DEPTH;
            if (slot_val[s] > slot_val[max_slot]) max_slot = s;
          end
        end
      end
    end
    r.queue_empty = (held == 0);
    r.max = (held == 0) ? NONE_VALUE : slot_val[max_slot];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      head_slot = 0;
      held = 0;
      max_slot = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with no expected result pending");
          fail_count++;
        end else begin
          due = expected_results.pop_front();
          checked++;
          if (popped_value !== due.popped) begin
            $error("popped_value: expected %0d, got %0d", due.popped, popped_value);
            fail_count++;
          end
          if (pop_empty !== due.pop_empty) begin
            $error("pop_empty: expected %0d, got %0d", due.pop_empty, pop_empty);
            fail_count++;
          end
          if (peak_value !== due.max) begin
            $error("peak_value: expected %0d, got %0d", due.max, peak_value);
            fail_count++;
          end
          if (queue_empty !== due.queue_empty) begin
            $error("queue_empty: expected %0d, got %0d", due.queue_empty, queue_empty);
            fail_count++;
          end
          if (push_dropped !== due.dropped) begin
            $error("push_dropped: expected %0d, got %0d", due.dropped, push_dropped);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_word(req_type, push_value));
      end
    end
    pending <= expected_results.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/fifo_with_running_max_unit_tb.sv
`default_nettype none

module fifo_with_running_max_unit_tb;
  import fwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [OUT_WIDTH-1:0] MOST_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};
  localparam logic signed [OUT_WIDTH-1:0] MOST_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  req_type;
  logic signed [OUT_WIDTH-1:0] push_value;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [OUT_WIDTH-1:0] popped_value;
  logic                        pop_empty;
  logic signed [OUT_WIDTH-1:0] peak_value;
  logic                        queue_empty;
  logic                        push_dropped;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int cycle_count;
  int n_push;
  int n_pop;
  int n_query;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  fifo_with_running_max_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .pop_empty    (pop_empty),
    .peak_value   (peak_value),
    .queue_empty  (queue_empty),
    .push_dropped (push_dropped)
  );

  fwm_max_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .pop_empty    (pop_empty),
    .peak_value   (peak_value),
    .queue_empty  (queue_empty),
    .push_dropped (push_dropped),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A hold-off request keeps the result side stalled while hold_cycles counts down.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic signed [OUT_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2, 3, 4, 5: return $signed($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input req_t req, input logic signed [OUT_WIDTH-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    push_value <= v;
    do @(posedge clk); while (in_stall);
    case (req)
      REQ_PUSH: n_push++;
      REQ_POP:  n_pop++;
      default:  n_query++;
    endcase
  endtask

  task automatic run_directed();
    int i;
    send_word(REQ_POP, $urandom);
    send_word(REQ_SPARE, $urandom);
    send_word(REQ_PUSH, MOST_NEG);
    send_word(REQ_PUSH, MOST_POS);
    send_word(REQ_PUSH, '0);
    send_word(REQ_PUSH, MOST_POS);
    send_word(REQ_QUERY, $urandom);
    send_word(REQ_POP, $urandom);
    send_word(REQ_POP, $urandom);
    for (i = 0; i < QUEUE_DEPTH - 2; i++) begin
      send_word(REQ_PUSH, 13 - 2 * i);
    end
    send_word(REQ_PUSH, MOST_POS);
    send_word(REQ_POP, $urandom);
  endtask

  task automatic run_random(input int count);
    int i;
    int push_pct;
    int sel;
    push_pct = 50;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 75;
          1: push_pct = 50;
          default: push_pct = 25;
        endcase
      end
      sel = $urandom_range(99);
      if (sel < 8) send_word(REQ_QUERY, $urandom);
      else if (sel < 11) send_word(REQ_SPARE, $urandom);
      else if ($urandom_range(99) < push_pct) send_word(REQ_PUSH, pick_value());
      else send_word(REQ_POP, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_QUERY;
    push_value = '0;
    hold_cycles = 0;
    n_push = 0;
    n_pop = 0;
    n_query = 0;
    send_idle_pct = 28;
    recv_idle_pct = 61;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    hold_cycles = 120;
    run_random(375);

    send_idle_pct = 61;
    recv_idle_pct = 28;
    run_random(375);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(400);

    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words: %0d pushes, %0d pops, %0d queries; %0d results compared.",
             n_push + n_pop + n_query, n_push, n_pop, n_query, checked);
    $display("Covered empty and full queues, ties, extreme values and a long result stall.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
